[rtl/mee_pkg.sv]
// Shared constants, types and helpers of the sum-of-exponentials evaluator.
`default_nettype none
package mee_pkg;

  // Fixed-point format and sizes
  localparam int FRAC_BITS = 16;
  localparam int MAX_TERMS = 5;
  localparam int X_W       = 32;
  localparam int Y_W       = 48;
  localparam int E_W       = Y_W - 1;
  localparam int PAIR_W    = 64;
  localparam int FORM_W    = 2;
  localparam int CNT_W     = 3;
  localparam int IDX_W     = 3;
  localparam int POS_W     = 3;
  localparam int PSUM_W    = 36;
  localparam int T_W       = FRAC_BITS + 9;
  localparam int U_W       = T_W + 32;
  localparam int K_W       = 10;
  localparam int F_W       = 30;
  localparam int P_W       = 32;
  localparam int HORNER    = 7;
  localparam int CELL_LAT  = 15;
  localparam int PV_W      = FRAC_BITS + 10;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_FORM  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_COUNT = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_CONST = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_PAIR0 = IDX_W'(3);

  // Reset values
  localparam logic [FORM_W-1:0] FORM_RST  = '0;
  localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(1);
  localparam logic [X_W-1:0]    CONST_RST = X_W'(1) << FRAC_BITS;
  localparam logic [PAIR_W-1:0] PAIR_RST  = {CONST_RST, -CONST_RST};

  // Saturation bounds
  localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};
  localparam logic [63:0] E_MAX64 = {{(64-Y_W+1){1'b0}}, {(Y_W-1){1'b1}}};
  localparam logic signed [63:0] ARG_LIMIT = 64'sd128 <<< FRAC_BITS;

  // Exponential constants: log2(e) and 2^f polynomial, both Q30
  localparam logic signed [U_W-1:0] LOG2E_U = U_W'(1549082005);
  localparam logic [P_W-1:0] POLY [0:7] = '{
    32'd1073741824, 32'd744261118, 32'd257941248, 32'd59597083,
    32'd10327388, 32'd1431680, 32'd165394, 32'd16378
  };
  localparam logic signed [K_W:0] SH_BIAS = (K_W+1)'(FRAC_BITS - 30);
  localparam int MUL_UP = 24 - FRAC_BITS;

  // Penalty constants
  localparam int PEN_SCALE = 1000;
  localparam int PEN_BASE  = PEN_SCALE << FRAC_BITS;
  localparam logic [PV_W-1:0] PEN_1 = PV_W'(PEN_BASE);
  localparam logic [PV_W-1:0] PEN_2 = PV_W'(PEN_BASE / 2);
  localparam logic [PV_W-1:0] PEN_3 = PV_W'(PEN_BASE / 3);
  localparam logic [PV_W-1:0] PEN_4 = PV_W'(PEN_BASE / 4);
  localparam logic [PV_W-1:0] PEN_5 = PV_W'(PEN_BASE / 5);

  // Running values handed from cell to cell, with the sample they belong to
  typedef struct packed {
    logic signed [X_W-1:0]    x;
    logic signed [Y_W-1:0]    y;
    logic                     ovf;
    logic signed [PSUM_W-1:0] psum;
    logic [POS_W-1:0]         pos;
  } acc_t;

  // Saturating add, returns {overflow, sum}
  function automatic logic [Y_W:0] sat_add(input logic signed [Y_W-1:0] a,
                                           input logic signed [Y_W-1:0] b);
    logic signed [Y_W:0] s;
    logic [Y_W:0] r;
    s = {a[Y_W-1], a} + {b[Y_W-1], b};
    if (s[Y_W] != s[Y_W-1]) begin
      r = {1'b1, (s[Y_W] ? Y_MIN : Y_MAX)};
    end else begin
      r = {1'b0, s[Y_W-1:0]};
    end
    return r;
  endfunction

  // Penalty per positive rate for a clamped term count
  function automatic logic [PV_W-1:0] pen_step(input logic [CNT_W-1:0] n);
    logic [PV_W-1:0] r;
    unique case (n)
      CNT_W'(2): r = PEN_2;
      CNT_W'(3): r = PEN_3;
      CNT_W'(4): r = PEN_4;
      CNT_W'(5): r = PEN_5;
      default:   r = PEN_1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/mee_cell.sv]
// One term cell: exp(rate*x), prefactor scaling and saturating accumulate.
`default_nettype none
module mee_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              adv_i,
  input  wire logic                              active_i,
  input  wire logic [mee_pkg::PAIR_W-1:0]        pair_i,
  input  wire logic                              vld_i,
  input  wire mee_pkg::acc_t                     acc_i,
  output logic                                   vld_o,
  output mee_pkg::acc_t                          acc_o
);

  localparam int L = mee_pkg::CELL_LAT;
  localparam int H = mee_pkg::HORNER;

  logic signed [31:0] pref, rate;
  assign pref = pair_i[63:32];
  assign rate = pair_i[31:0];

  // valid and running-value shift line
  logic          vld_q [0:L-1];
  mee_pkg::acc_t acc_q [0:L-1];

  // exp datapath registers
  logic signed [63:0]             prod_q;
  logic signed [mee_pkg::T_W-1:0] t_q;
  logic                           hi2_q, lo2_q, hi3_q, lo3_q;
  logic signed [mee_pkg::U_W-1:0] u_q;
  logic signed [mee_pkg::K_W-1:0] k_q  [0:H];
  logic [mee_pkg::F_W-1:0]        f_q  [0:H];
  logic                           hi_q [0:H];
  logic                           lo_q [0:H];
  logic [mee_pkg::P_W-1:0]        p_q  [1:H];
  logic [mee_pkg::E_W-1:0]        e_q;
  logic                           eovf_q, eovf13_q, movf_q;
  logic [54:0]                    ph_q;
  logic [55:0]                    pl_q;
  logic [mee_pkg::E_W-1:0]        mag_q;

  // stage 2 comb
  logic signed [63:0] t_full;
  assign t_full = prod_q >>> mee_pkg::FRAC_BITS;

  // stage 3 comb
  logic signed [mee_pkg::U_W-1:0] t_ext;
  assign t_ext = {{(mee_pkg::U_W-mee_pkg::T_W){t_q[mee_pkg::T_W-1]}}, t_q};

  // Horner steps, one per stage
  logic [mee_pkg::P_W-1:0] p_nx [0:H-1];
  always_comb begin
    logic [mee_pkg::P_W-1:0] pp;
    logic [61:0]             prd;
    for (int h = 0; h < H; h++) begin
      pp = (h == 0) ? mee_pkg::POLY[7] : p_q[(h == 0) ? 1 : h];
      prd = {30'b0, pp} * {32'b0, f_q[h]};
      p_nx[h] = mee_pkg::POLY[6-h] + prd[61:30];
    end
  end

  // final shift of the Q30 power by k
  logic [mee_pkg::E_W-1:0] e_d;
  logic                    eovf_d;
  always_comb begin
    logic signed [mee_pkg::K_W:0] s;
    logic [mee_pkg::K_W:0]        ns;
    logic [63:0]                  v;
    s = {k_q[H][mee_pkg::K_W-1], k_q[H]} + mee_pkg::SH_BIAS;
    ns = -s;
    v = {32'b0, p_q[H]} << s[5:0];
    e_d = '0;
    eovf_d = 1'b0;
    priority if (hi_q[H]) begin
      e_d = mee_pkg::E_MAX64[mee_pkg::E_W-1:0];
      eovf_d = 1'b1;
    end else if (lo_q[H]) begin
      e_d = '0;
    end else if (!s[mee_pkg::K_W]) begin
      if (s > (mee_pkg::K_W+1)'(32) || v > mee_pkg::E_MAX64) begin
        e_d = mee_pkg::E_MAX64[mee_pkg::E_W-1:0];
        eovf_d = 1'b1;
      end else begin
        e_d = v[mee_pkg::E_W-1:0];
      end
    end else if (ns >= (mee_pkg::K_W+1)'(32)) begin
      e_d = '0;
    end else begin
      e_d = mee_pkg::E_W'(p_q[H] >> ns[4:0]);
    end
  end

  // prefactor magnitude
  logic [31:0] a_mag;
  assign a_mag = pref[31] ? 32'(-pref) : 32'(pref);

  // product capping
  logic [mee_pkg::E_W-1:0] mag_d;
  logic                    msat;
  always_comb begin
    logic [63:0] r;
    r = ({9'b0, ph_q} << mee_pkg::MUL_UP) + ({8'b0, pl_q} >> mee_pkg::FRAC_BITS);
    msat = ({9'b0, ph_q} > (mee_pkg::E_MAX64 >> mee_pkg::MUL_UP)) ||
           (r > mee_pkg::E_MAX64);
    mag_d = msat ? mee_pkg::E_MAX64[mee_pkg::E_W-1:0] : r[mee_pkg::E_W-1:0];
  end

  // accumulate into the running values
  mee_pkg::acc_t acc_d;
  always_comb begin
    logic signed [mee_pkg::Y_W-1:0] term;
    logic [mee_pkg::Y_W:0]          sa;
    term = pref[31] ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    sa = mee_pkg::sat_add(acc_q[L-2].y, term);
    acc_d = acc_q[L-2];
    if (active_i) begin
      acc_d.y = sa[mee_pkg::Y_W-1:0];
      acc_d.ovf = acc_q[L-2].ovf | sa[mee_pkg::Y_W] | movf_q;
      acc_d.psum = acc_q[L-2].psum +
                   {{(mee_pkg::PSUM_W-32){pref[31]}}, pref};
      acc_d.pos = acc_q[L-2].pos + mee_pkg::POS_W'(!rate[31] && rate != '0);
    end
  end

  // valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < L; s++) vld_q[s] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= vld_i;
      for (int s = 1; s < L; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q[0] <= acc_i;
      for (int s = 1; s < L - 1; s++) acc_q[s] <= acc_q[s-1];
      acc_q[L-1] <= acc_d;
      prod_q <= {{32{rate[31]}}, rate} *
                {{32{acc_i.x[mee_pkg::X_W-1]}}, acc_i.x};
      t_q   <= mee_pkg::T_W'(t_full);
      hi2_q <= t_full > mee_pkg::ARG_LIMIT;
      lo2_q <= t_full < -mee_pkg::ARG_LIMIT;
      u_q   <= t_ext * mee_pkg::LOG2E_U;
      hi3_q <= hi2_q;
      lo3_q <= lo2_q;
      k_q[0]  <= mee_pkg::K_W'(u_q >>> (mee_pkg::FRAC_BITS + 30));
      f_q[0]  <= u_q[mee_pkg::FRAC_BITS+29:mee_pkg::FRAC_BITS];
      hi_q[0] <= hi3_q;
      lo_q[0] <= lo3_q;
      for (int h = 1; h <= H; h++) begin
        k_q[h]  <= k_q[h-1];
        f_q[h]  <= f_q[h-1];
        hi_q[h] <= hi_q[h-1];
        lo_q[h] <= lo_q[h-1];
        p_q[h]  <= p_nx[h-1];
      end
      e_q    <= e_d;
      eovf_q <= eovf_d;
      ph_q   <= {23'b0, a_mag} * {32'b0, e_q[mee_pkg::E_W-1:24]};
      pl_q   <= {24'b0, a_mag} * {32'b0, e_q[23:0]};
      eovf13_q <= eovf_q;
      mag_q  <= mag_d;
      movf_q <= eovf13_q | msat;
    end
  end

  assign vld_o = vld_q[L-1];
  assign acc_o = acc_q[L-1];

endmodule
`default_nettype wire

[rtl/mee_tail.sv]
// Penalty stages and output register after the last term cell.
`default_nettype none
module mee_tail (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              adv_i,
  input  wire logic                              use_pen_i,
  input  wire logic [mee_pkg::CNT_W-1:0]         n_i,
  input  wire logic                              vld_i,
  input  wire mee_pkg::acc_t                     acc_i,
  output logic                                   vld_o,
  output logic signed [mee_pkg::Y_W-1:0]         y_o,
  output logic                                   ovf_o
);

  logic                            v1_q, v2_q, v3_q;
  logic signed [mee_pkg::Y_W-1:0]  y1_q, y2_q, y3_q, d1_q;
  logic                            o1_q, o2_q, o3_q;
  logic [mee_pkg::Y_W-1:0]         pv1_q, pv2_q;

  // penalty one: 1000 * (1.0 - constant - sum of prefactors)
  logic signed [mee_pkg::PSUM_W:0] diff;
  logic signed [mee_pkg::Y_W-1:0]  d1_d;
  assign diff = (mee_pkg::PSUM_W+1)'(1 << mee_pkg::FRAC_BITS) -
                {acc_i.psum[mee_pkg::PSUM_W-1], acc_i.psum};
  assign d1_d = {{(mee_pkg::Y_W-mee_pkg::PSUM_W-1){diff[mee_pkg::PSUM_W]}}, diff} *
                mee_pkg::Y_W'(mee_pkg::PEN_SCALE);

  logic [mee_pkg::Y_W:0] sa2, sa3;
  assign sa2 = mee_pkg::sat_add(y1_q, d1_q);
  assign sa3 = mee_pkg::sat_add(y2_q, $signed(pv2_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      y1_q  <= acc_i.y;
      o1_q  <= acc_i.ovf;
      d1_q  <= d1_d;
      pv1_q <= {{(mee_pkg::Y_W-mee_pkg::PV_W){1'b0}}, mee_pkg::pen_step(n_i)} *
               {{(mee_pkg::Y_W-mee_pkg::POS_W){1'b0}}, acc_i.pos};
      pv2_q <= pv1_q;
      y2_q <= use_pen_i ? sa2[mee_pkg::Y_W-1:0] : y1_q;
      o2_q <= o1_q | (use_pen_i & sa2[mee_pkg::Y_W]);
      y3_q <= use_pen_i ? sa3[mee_pkg::Y_W-1:0] : y2_q;
      o3_q <= o2_q | (use_pen_i & sa3[mee_pkg::Y_W]);
    end
  end

  assign vld_o = v3_q;
  assign y_o   = y3_q;
  assign ovf_o = o3_q;

endmodule
`default_nettype wire

[rtl/multi_exponential_evaluator.sv]
// Top level: configuration registers and the chain of term cells.
//
// Usage: X words enter on the in_valid_i/in_ready_o channel, Y words with an
// overflow flag leave on out_valid_o/out_ready_i. Each X gives exactly one Y.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write them only while no word is in flight, the block does not enforce it.
// Datapath: a row of five identical term cells, each 15 stages deep
// (product, range reduction, seven Horner steps, shift, prefactor multiply,
// capping, saturating add), followed by two penalty stages and the output
// register, 78 stages in all.
// Throughput is one word per cycle while the receiver takes results.
// The whole pipeline advances together: when out_valid_o is high and
// out_ready_i low, every stage holds and in_ready_o drops, so the result
// on the output stays stable until taken.
// Reset clears all valid bits and loads the register defaults: form 0, one
// term, constant 1.0, every term with prefactor 1.0 and rate -1.0.
`default_nettype none
module multi_exponential_evaluator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [mee_pkg::IDX_W-1:0]         cfg_idx_i,
  input  wire logic [mee_pkg::PAIR_W-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [mee_pkg::X_W-1:0]    x_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [mee_pkg::Y_W-1:0]         y_value_o,
  output logic                                   overflow_o
);

  localparam int N = mee_pkg::MAX_TERMS;

  logic [mee_pkg::FORM_W-1:0] form_q;
  logic [mee_pkg::CNT_W-1:0]  count_q;
  logic [mee_pkg::X_W-1:0]    const_q;
  logic [mee_pkg::PAIR_W-1:0] pair_q [0:N-1];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      form_q  <= mee_pkg::FORM_RST;
      count_q <= mee_pkg::COUNT_RST;
      const_q <= mee_pkg::CONST_RST;
      for (int i = 0; i < N; i++) pair_q[i] <= mee_pkg::PAIR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mee_pkg::REG_FORM:  form_q  <= cfg_wdata_i[mee_pkg::FORM_W-1:0];
        mee_pkg::REG_COUNT: count_q <= cfg_wdata_i[mee_pkg::CNT_W-1:0];
        mee_pkg::REG_CONST: const_q <= cfg_wdata_i[mee_pkg::X_W-1:0];
        default:            pair_q[cfg_idx_i - mee_pkg::REG_PAIR0] <= cfg_wdata_i;
      endcase
    end
  end

  // clamped term count
  logic [mee_pkg::CNT_W-1:0] n_eff;
  always_comb begin
    priority if (count_q == '0) n_eff = mee_pkg::CNT_W'(1);
    else if (count_q > mee_pkg::CNT_W'(N)) n_eff = mee_pkg::CNT_W'(N);
    else n_eff = count_q;
  end

  logic use_const, use_pen, adv;
  assign use_const = form_q != '0;
  assign use_pen   = form_q[1];
  assign adv       = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // starting values: the sample and the constant term when enabled
  mee_pkg::acc_t acc0;
  always_comb begin
    acc0.x    = x_value_i;
    acc0.y    = use_const ? {{(mee_pkg::Y_W-mee_pkg::X_W){const_q[mee_pkg::X_W-1]}}, const_q}
                          : '0;
    acc0.psum = use_const ? {{(mee_pkg::PSUM_W-mee_pkg::X_W){const_q[mee_pkg::X_W-1]}},
                             const_q} : '0;
    acc0.ovf  = 1'b0;
    acc0.pos  = '0;
  end

  logic          vld_c [0:N];
  mee_pkg::acc_t acc_c [0:N];
  assign vld_c[0] = in_valid_i;
  assign acc_c[0] = acc0;

  // chain of term cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    mee_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .active_i (mee_pkg::CNT_W'(i) < n_eff),
      .pair_i   (pair_q[i]),
      .vld_i    (vld_c[i]),
      .acc_i    (acc_c[i]),
      .vld_o    (vld_c[i+1]),
      .acc_o    (acc_c[i+1])
    );
  end

  mee_tail u_tail (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .use_pen_i (use_pen),
    .n_i       (n_eff),
    .vld_i     (vld_c[N]),
    .acc_i     (acc_c[N]),
    .vld_o     (out_valid_o),
    .y_o       (y_value_o),
    .ovf_o     (overflow_o)
  );

endmodule
`default_nettype wire

[rtl/mee_checker.sv]
// Port-level checks of the evaluator, bound to the top level.
`default_nettype none
module mee_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic signed [mee_pkg::Y_W-1:0] y_value_o,
  input wire logic                           overflow_o
);

  // a stalled word stays on the output
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(y_value_o) && $stable(overflow_o))
    else $error("output word changed while stalled");

  // input is taken exactly when the pipeline can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // nothing leaves during reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind multi_exponential_evaluator mee_checker u_mee_checker (.*);
`default_nettype wire

[test/mee_checker.sv]
// Scoreboard for the sum-of-exponentials evaluator: predicts Y per X and compares.
module mee_scoreboard (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mee_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [mee_pkg::PAIR_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic signed [mee_pkg::X_W-1:0]    x_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [mee_pkg::Y_W-1:0]    y_value_i,
  input  logic                              overflow_i,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                y_seen_o,
  output int                                ovf_seen_o
);
  import mee_pkg::*;

  typedef struct packed {
    logic signed [Y_W-1:0] y;
    logic                  ovf;
  } y_word_t;

  localparam longint YMX = 64'sh7FFF_FFFF_FFFF;
  localparam longint YMN = -64'sh8000_0000_0000;

  // Shadow copy of the registers
  logic [FORM_W-1:0] form_q;
  logic [CNT_W-1:0]  count_q;
  logic [X_W-1:0]    const_q;
  logic [PAIR_W-1:0] pair_q [MAX_TERMS];

  y_word_t y_queue [$];

  function automatic longint floor_div(longint p, int sh);
    return p >>> sh;
  endfunction

  function automatic longint sat_sum(longint a, longint b, ref bit ovf);
    longint r;
    r = a + b;
    if (r > YMX) begin
      ovf = 1;
      r = YMX;
    end else if (r < YMN) begin
      ovf = 1;
      r = YMN;
    end
    return r;
  endfunction

  // exp of a Q16.16 argument, result in [0, 2^47-1]
  function automatic longint exp_fixed(longint t, ref bit ovf);
    longint u, k, fr, f, p, s;
    longint unsigned v;
    longint cf [8];
    cf = '{1073741824, 744261118, 257941248, 59597083, 10327388, 1431680,
           165394, 16378};
    if (t > (longint'(128) << FRAC_BITS)) begin
      ovf = 1;
      return YMX;
    end
    if (t < -(longint'(128) << FRAC_BITS)) return 0;
    u = t * 1549082005;
    k = u >>> (FRAC_BITS + 30);
    fr = u - (k <<< (FRAC_BITS + 30));
    f = fr >>> FRAC_BITS;
    p = cf[7];
    for (int i = 6; i >= 0; i--) p = cf[i] + ((p * f) >>> 30);
    s = k + FRAC_BITS - 30;
    if (s >= 0) begin
      if (s > 32) begin
        ovf = 1;
        return YMX;
      end
      v = longint'(p) << s;
      if (v > longint'(YMX)) begin
        ovf = 1;
        return YMX;
      end
      return v;
    end
    if (-s >= 63) return 0;
    return longint'(longint'(p) >>> (-s));
  endfunction

  function automatic longint scale_term(longint unsigned a, longint unsigned e,
                                        ref bit ovf);
    longint unsigned ph, pl, r;
    ph = a * (e >> 24);
    pl = a * (e & 64'hFF_FFFF);
    if (ph > (longint'(YMX) >> (24 - FRAC_BITS))) begin
      ovf = 1;
      return YMX;
    end
    r = (ph << (24 - FRAC_BITS)) + (pl >> FRAC_BITS);
    if (r > longint'(YMX)) begin
      ovf = 1;
      return YMX;
    end
    return r;
  endfunction

  function automatic y_word_t predict_y(logic signed [X_W-1:0] xv);
    bit ovf;
    longint x, y, psum, a, r, e, mag, pval;
    int n, positive;
    y_word_t w;
    ovf = 0;
    y = 0;
    psum = 0;
    positive = 0;
    x = xv;
    n = count_q;
    if (n < 1) n = 1;
    if (n > MAX_TERMS) n = MAX_TERMS;
    if (form_q != 0) begin
      y = sat_sum(y, longint'($signed(const_q)), ovf);
      psum = longint'($signed(const_q));
    end
    for (int i = 0; i < n; i++) begin
      a = longint'($signed(pair_q[i][63:32]));
      r = longint'($signed(pair_q[i][31:0]));
      e = exp_fixed(floor_div(r * x, FRAC_BITS), ovf);
      mag = scale_term(a < 0 ? -a : a, e, ovf);
      y = sat_sum(y, a < 0 ? -mag : mag, ovf);
      psum += a;
      if (r > 0) positive++;
    end
    if (form_q[1]) begin
      pval = (longint'(1000) << FRAC_BITS) / n;
      y = sat_sum(y, ((longint'(1) << FRAC_BITS) - psum) * 1000, ovf);
      y = sat_sum(y, pval * positive, ovf);
    end
    w.y = y[Y_W-1:0];
    w.ovf = ovf;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    y_word_t w;
    int errs;
    if (!rst_ni) begin
      form_q <= FORM_RST;
      count_q <= COUNT_RST;
      const_q <= CONST_RST;
      for (int i = 0; i < MAX_TERMS; i++) pair_q[i] <= PAIR_RST;
      fail_count_o <= 0;
      pending_o <= 0;
      y_seen_o <= 0;
      ovf_seen_o <= 0;
      y_queue.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FORM:  form_q <= cfg_wdata_i[FORM_W-1:0];
          REG_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
          REG_CONST: const_q <= cfg_wdata_i[X_W-1:0];
          default: begin
            if (cfg_idx_i >= REG_PAIR0 && cfg_idx_i < REG_PAIR0 + MAX_TERMS)
              pair_q[cfg_idx_i - REG_PAIR0] <= cfg_wdata_i;
          end
        endcase
      end
      if (in_valid_i && in_ready_i) y_queue.insert(y_queue.size(), predict_y(x_value_i));
      if (out_valid_i && out_ready_i) begin
        y_seen_o <= y_seen_o + 1;
        if (overflow_i) ovf_seen_o <= ovf_seen_o + 1;
        if (y_queue.size() == 0) begin
          $error("unexpected word: y_value %h", y_value_i);
          errs++;
        end else begin
          w = y_queue.pop_front();
          if (w.y !== y_value_i) begin
            $error("y_value expected %h actual %h", w.y, y_value_i);
            errs++;
          end
          if (w.ovf !== overflow_i) begin
            $error("overflow expected %b actual %b", w.ovf, overflow_i);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
      pending_o <= y_queue.size();
    end
  end

endmodule

[test/testbench.sv]
// Stimulus and verdict for the sum-of-exponentials evaluator.
module testbench;
  import mee_pkg::*;

  localparam int LATENCY = 78;
  localparam int STALL_LIMIT = 5000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [PAIR_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  logic signed [X_W-1:0] x_value_i;
  logic out_valid_o, out_ready_i;
  logic signed [Y_W-1:0] y_value_o;
  logic overflow_o;
  int fail_count, pending, y_seen, ovf_seen;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;
  int idle_cycles;
  int words_sent;

  multi_exponential_evaluator DUT (.*);

  mee_scoreboard u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .x_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .y_value_i(y_value_o),
    .overflow_i(overflow_o), .fail_count_o(fail_count), .pending_o(pending),
    .y_seen_o(y_seen), .ovf_seen_o(ovf_seen)
  );

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when asked
  initial begin
    int n;
    out_ready_i = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        for (n = 0; n < 200; n++) @(posedge clk_i);
        hold_off = 0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [PAIR_W-1:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain_words();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_x(logic signed [X_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    x_value_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Q16.16 value with moderate magnitude so exponentials stay in range mostly
  function automatic logic [31:0] small_q(int mag);
    int v;
    v = $urandom_range(2 * mag) - mag;
    return 32'(v);
  endfunction

  function automatic logic [PAIR_W-1:0] rand_pair(bit wide);
    logic [31:0] a, r;
    a = wide ? $urandom : small_q(4 << FRAC_BITS);
    r = wide ? $urandom : small_q(2 << FRAC_BITS);
    return {a, r};
  endfunction

  task automatic random_setting(bit wide);
    write_reg(REG_FORM, PAIR_W'($urandom_range(3)));
    write_reg(REG_COUNT, PAIR_W'($urandom_range(7)));
    write_reg(REG_CONST, PAIR_W'(wide ? $urandom : small_q(8 << FRAC_BITS)));
    for (int i = 0; i < MAX_TERMS; i++)
      write_reg(REG_PAIR0 + IDX_W'(i), rand_pair(wide));
  endtask

  function automatic logic signed [X_W-1:0] rand_x();
    case ($urandom_range(3))
      0: return $urandom;
      1: return small_q(1 << FRAC_BITS);
      default: return small_q(16 << FRAC_BITS);
    endcase
  endfunction

  initial begin
    logic signed [X_W-1:0] edge_x [8];
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 0;
    x_value_i = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 0;
    words_sent = 0;
    edge_x = '{32'sh7FFF_FFFF, -32'sh8000_0000, 0, 32'sh1_0000, -32'sh1_0000,
               32'sh80_0000, -32'sh80_0000, 32'sh0000_0001};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset registers, then each form, count extremes, huge/tiny args
    for (int f = 0; f < 4; f++) begin
      if (f > 0) begin
        write_reg(REG_FORM, PAIR_W'(f));
        write_reg(REG_COUNT, PAIR_W'(f == 3 ? 0 : (f == 2 ? 7 : 5)));
        write_reg(REG_CONST, f == 2 ? 64'h8000_0000 : 64'h7FFF_FFFF);
        write_reg(REG_PAIR0, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        write_reg(REG_PAIR0 + IDX_W'(1), {32'h8000_0000, 32'h0001_0000});
        write_reg(REG_PAIR0 + IDX_W'(2), {32'h0001_0000, 32'h8000_0000});
        write_reg(REG_PAIR0 + IDX_W'(3), {32'hFFFF_0000, 32'h0000_0000});
        write_reg(REG_PAIR0 + IDX_W'(4), {32'h0000_0000, 32'hFFFF_FFFF});
      end
      for (int i = 0; i < 6; i++) send_x(edge_x[i + (f & 1) * 2]);
      in_valid_i <= 0;
      drain_words();
    end

    // Random phases under three idling regimes
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 33 : (ph < 8) ? 56 : 0;
      recv_idle_pct = (ph < 4) ? 56 : (ph < 8) ? 33 : 0;
      random_setting(ph % 4 == 3);
      if (ph == 9) hold_off = 1;
      for (int i = 0; i < 40; i++) send_x(rand_x());
      in_valid_i <= 0;
      // sender waits out every result before the register writes
      drain_words();
    end
    repeat (LATENCY) @(posedge clk_i);

    $display("Sent %0d X words over all forms and term counts;", words_sent);
    $display("%0d Y words checked, %0d of them saturated.", y_seen, ovf_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

[multi_exponential_evaluator.f]
rtl/mee_pkg.sv
rtl/mee_cell.sv
rtl/mee_tail.sv
rtl/multi_exponential_evaluator.sv
rtl/mee_checker.sv
test/mee_checker.sv
test/testbench.sv
